// ----- rtl/core/lrwd_pkg.sv -----
// Shared types and constants for the LZSS ring-window decoder.
package lrwd_pkg;

	// Window store geometry.
	localparam int WIN_DEPTH = 4096;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);

	// Output packing.
	localparam int OUT_LANES = 4;
	localparam int LANE_W    = $clog2(OUT_LANES);
	localparam int CNT_W     = 3;
	localparam int OUT_W     = 8 * OUT_LANES;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_MODE   = 1'b0,
		REG_OUTPUT_LENGTH = 1'b1
	} lrwd_reg_t;

	// Index masks for the two window sizes.
	localparam logic [WIN_AW-1:0] WIN_MASK_FULL  = WIN_AW'(4096 - 1);
	localparam logic [WIN_AW-1:0] WIN_MASK_SMALL = WIN_AW'(512 - 1);

	// Start of the write pointer: window size minus the longest match.
	localparam logic [WIN_AW-1:0] WPOS_RST_FULL  = WIN_AW'(4096 - 18);
	localparam logic [WIN_AW-1:0] WPOS_RST_SMALL = WIN_AW'(512 - 130);

	// Match length bias.
	localparam logic [7:0] LEN_BIAS = 8'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} lrwd_state_t;

endpackage

// ----- rtl/core/lzss_ring_window_decoder_unit.sv -----
// LZSS ring-window decoder: flag parsing, window copy sequencer and output packing.
//
// This block decodes the body of an LZSS stream, one compressed byte per input
// transfer, and returns the decompressed bytes packed up to four per output
// transfer, the first byte in the lowest eight bits and unused lanes zero.
// Flag bytes and the first byte of a window reference produce no output. A
// literal produces one output transfer. A reference produces as many output
// transfers as its copy needs, and run_last marks the final one; stream_end
// marks the transfer that holds the last byte of the stream. Before a stream,
// write window_mode and then output_length; the output_length write rearms
// the decoder and starts a clearing pass that zeroes the 4096-byte window one
// entry per cycle, so the block accepts no input during that pass, which also
// runs after reset. Flag bytes, first reference bytes and literals are each
// handled as they are accepted. A reference is accepted and then copied with
// a read state and a write state per copied byte, because the single-ported
// window memory is read in one state and written with the copied byte in the
// next. Output back-pressure stalls the copy once a full word waits behind
// a full output register. When the stream is complete, further input bytes
// are taken and dropped until the next rearm.
module lzss_ring_window_decoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [lrwd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lrwd_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           in_byte,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lrwd_pkg::OUT_W-1:0]           out_bytes,
	output logic [lrwd_pkg::CNT_W-1:0]           byte_count,
	output logic                                 run_last,
	output logic                                 stream_end
);

	// Sequencer and stream state.
	lrwd_pkg::lrwd_state_t state_q, state_d;
	logic [lrwd_pkg::WIN_AW-1:0] clr_addr_q, clr_addr_d;
	logic                        window_mode_q, window_mode_d;
	logic [31:0]                 bytes_left_q, bytes_left_d;
	logic [lrwd_pkg::WIN_AW-1:0] write_pos_q, write_pos_d;
	logic [7:0]                  flag_bits_q, flag_bits_d;
	logic [3:0]                  flags_left_q, flags_left_d;
	logic                        phase_q, phase_d;
	logic [7:0]                  ref_first_q, ref_first_d;

	// Copy pointer and remaining length of the reference in flight.
	logic [lrwd_pkg::WIN_AW-1:0] src_q, src_d;
	logic [7:0]                  len_left_q, len_left_d;

	// Packing word, complete once pack_done_q is set.
	logic [lrwd_pkg::OUT_W-1:0]  pack_q, pack_d;
	logic [lrwd_pkg::CNT_W-1:0]  pack_cnt_q, pack_cnt_d;
	logic                        pack_done_q, pack_done_d;
	logic                        pack_last_q, pack_last_d;
	logic                        pack_end_q, pack_end_d;

	// Output register.
	logic                        out_valid_q;
	logic [lrwd_pkg::OUT_W-1:0]  out_bytes_q;
	logic [lrwd_pkg::CNT_W-1:0]  out_cnt_q;
	logic                        out_last_q;
	logic                        out_end_q;

	// Window memory port.
	logic [7:0]                  win_mem [lrwd_pkg::WIN_DEPTH];
	logic                        mem_we;
	logic [lrwd_pkg::WIN_AW-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic                        mem_re;
	logic [lrwd_pkg::WIN_AW-1:0] mem_raddr;
	logic [7:0]                  rd_q;

	// Helpers.
	logic                        out_load;
	logic                        pack_free;
	logic                        accept;
	logic [lrwd_pkg::WIN_AW-1:0] win_mask;
	logic                        append;
	logic [7:0]                  app_byte;
	logic                        app_run_end;
	logic                        app_end;
	logic [lrwd_pkg::CNT_W-1:0]  app_base;
	logic [lrwd_pkg::CNT_W-1:0]  app_cnt;
	logic                        last_byte;

	// The packing word moves into the output register when that register is
	// empty or is handing off its word in this cycle.
	assign out_load  = pack_done_q && (!out_valid_q || out_ready);
	assign pack_free = !pack_done_q || out_load;
	assign in_ready  = (state_q == lrwd_pkg::ST_IDLE) && pack_free;
	assign accept    = in_valid && in_ready;
	assign win_mask  = window_mode_q ? lrwd_pkg::WIN_MASK_SMALL : lrwd_pkg::WIN_MASK_FULL;
	assign last_byte = (bytes_left_q == 32'd1);

	always_comb begin
		state_d       = state_q;
		clr_addr_d    = clr_addr_q;
		window_mode_d = window_mode_q;
		bytes_left_d  = bytes_left_q;
		write_pos_d   = write_pos_q;
		flag_bits_d   = flag_bits_q;
		flags_left_d  = flags_left_q;
		phase_d       = phase_q;
		ref_first_d   = ref_first_q;
		src_d         = src_q;
		len_left_d    = len_left_q;
		pack_d        = pack_q;
		pack_cnt_d    = pack_cnt_q;
		pack_done_d   = pack_done_q;
		pack_last_d   = pack_last_q;
		pack_end_d    = pack_end_q;
		mem_we        = 1'b0;
		mem_waddr     = write_pos_q & win_mask;
		mem_wdata     = 8'h00;
		mem_re        = 1'b0;
		mem_raddr     = src_q;
		append        = 1'b0;
		app_byte      = 8'h00;
		app_run_end   = 1'b0;
		app_end       = 1'b0;
		app_base      = '0;
		app_cnt       = '0;

		if (out_load) begin
			pack_done_d = 1'b0;
			pack_cnt_d  = '0;
		end

		case (state_q)
			lrwd_pkg::ST_CLEAR: begin
				mem_we     = 1'b1;
				mem_waddr  = clr_addr_q;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == lrwd_pkg::WIN_AW'(lrwd_pkg::WIN_DEPTH - 1)) begin
					state_d = lrwd_pkg::ST_IDLE;
				end
			end
			lrwd_pkg::ST_IDLE: begin
				if (accept && bytes_left_q != 32'd0) begin
					if (flags_left_q == 4'd0) begin
						flag_bits_d  = in_byte;
						flags_left_d = 4'd8;
					end else if (flag_bits_q[0]) begin
						// Literal: one byte out and into the window.
						append       = 1'b1;
						app_byte     = in_byte;
						app_run_end  = 1'b1;
						app_end      = last_byte;
						mem_we       = 1'b1;
						mem_wdata    = in_byte;
						write_pos_d  = (write_pos_q + 1'b1) & win_mask;
						bytes_left_d = bytes_left_q - 32'd1;
						flag_bits_d  = flag_bits_q >> 1;
						flags_left_d = flags_left_q - 4'd1;
					end else if (!phase_q) begin
						ref_first_d = in_byte;
						phase_d     = 1'b1;
					end else begin
						// Second reference byte: offset high bits and length.
						if (!window_mode_q) begin
							src_d      = {in_byte[7:4], ref_first_q};
							len_left_d = {4'b0000, in_byte[3:0]} + lrwd_pkg::LEN_BIAS;
						end else begin
							src_d      = {3'b000, in_byte[7], ref_first_q};
							len_left_d = {1'b0, in_byte[6:0]} + lrwd_pkg::LEN_BIAS;
						end
						phase_d      = 1'b0;
						flag_bits_d  = flag_bits_q >> 1;
						flags_left_d = flags_left_q - 4'd1;
						state_d      = lrwd_pkg::ST_READ;
					end
				end
			end
			lrwd_pkg::ST_READ: begin
				// Read only when the byte can be packed in the next cycle.
				if (pack_free) begin
					mem_re  = 1'b1;
					state_d = lrwd_pkg::ST_WRITE;
				end
			end
			lrwd_pkg::ST_WRITE: begin
				append       = 1'b1;
				app_byte     = rd_q;
				app_run_end  = (len_left_q == 8'd1) || last_byte;
				app_end      = last_byte;
				bytes_left_d = bytes_left_q - 32'd1;
				// The final byte of the stream is not written back.
				if (!last_byte) begin
					mem_we      = 1'b1;
					mem_wdata   = rd_q;
					write_pos_d = (write_pos_q + 1'b1) & win_mask;
				end
				src_d      = (src_q + 1'b1) & win_mask;
				len_left_d = len_left_q - 8'd1;
				state_d    = app_run_end ? lrwd_pkg::ST_IDLE : lrwd_pkg::ST_READ;
			end
			default: begin
				state_d    = lrwd_pkg::ST_CLEAR;
				clr_addr_d = '0;
			end
		endcase

		// Append one byte to the packing word; a fresh word starts from zero.
		if (append) begin
			app_base = pack_done_q ? '0 : pack_cnt_q;
			app_cnt  = app_base + 1'b1;
			if (app_base == '0) begin
				pack_d = '0;
			end
			pack_d[{app_base[lrwd_pkg::LANE_W-1:0], 3'b000} +: 8] = app_byte;
			pack_cnt_d  = app_cnt;
			pack_done_d = app_run_end || (app_cnt == lrwd_pkg::CNT_W'(lrwd_pkg::OUT_LANES));
			pack_last_d = app_run_end;
			pack_end_d  = app_run_end && app_end;
		end

		if (cfg_we) begin
			case (cfg_index)
				lrwd_pkg::REG_WINDOW_MODE: begin
					window_mode_d = cfg_data[0];
				end
				lrwd_pkg::REG_OUTPUT_LENGTH: begin
					bytes_left_d = cfg_data;
					flag_bits_d  = 8'h00;
					flags_left_d = 4'd0;
					phase_d      = 1'b0;
					write_pos_d  = window_mode_q ? lrwd_pkg::WPOS_RST_SMALL
					                             : lrwd_pkg::WPOS_RST_FULL;
					state_d      = lrwd_pkg::ST_CLEAR;
					clr_addr_d   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lrwd_pkg::ST_CLEAR;
			clr_addr_q    <= '0;
			window_mode_q <= 1'b0;
			bytes_left_q  <= 32'd0;
			write_pos_q   <= lrwd_pkg::WPOS_RST_FULL;
			flag_bits_q   <= 8'h00;
			flags_left_q  <= 4'd0;
			phase_q       <= 1'b0;
			pack_cnt_q    <= '0;
			pack_done_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			clr_addr_q    <= clr_addr_d;
			window_mode_q <= window_mode_d;
			bytes_left_q  <= bytes_left_d;
			write_pos_q   <= write_pos_d;
			flag_bits_q   <= flag_bits_d;
			flags_left_q  <= flags_left_d;
			phase_q       <= phase_d;
			pack_cnt_q    <= pack_cnt_d;
			pack_done_q   <= pack_done_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ref_first_q <= ref_first_d;
		src_q       <= src_d;
		len_left_q  <= len_left_d;
		pack_q      <= pack_d;
		pack_last_q <= pack_last_d;
		pack_end_q  <= pack_end_d;
		if (out_load) begin
			out_bytes_q <= pack_q;
			out_cnt_q   <= pack_cnt_q;
			out_last_q  <= pack_last_q;
			out_end_q   <= pack_end_q;
		end
	end

	// Single-ported window memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= win_mem[mem_raddr];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_bytes  = out_bytes_q;
	assign byte_count = out_cnt_q;
	assign run_last   = out_last_q;
	assign stream_end = out_end_q;

endmodule

// ----- bench/lzss_ring_window_decoder_unit_chk.sv -----
// Checker that predicts the decoder's output words and compares every transfer.
`timescale 1ns / 100ps
module lzss_ring_window_decoder_unit_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lrwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrwd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [7:0]                        in_byte,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [lrwd_pkg::OUT_W-1:0]        out_bytes,
	input  logic [lrwd_pkg::CNT_W-1:0]        byte_count,
	input  logic                              run_last,
	input  logic                              stream_end,
	output int                                fail_count,
	output int                                pending
);
	import lrwd_pkg::*;

	localparam int MAX_COPY = 130;

	typedef struct packed {
		logic [OUT_W-1:0] data;
		logic [CNT_W-1:0] count;
		logic             last;
		logic             done;
	} word_t;

	word_t             predicted_words[$];
	logic [7:0]        history [0:WIN_DEPTH-1];
	logic [WIN_AW-1:0] wr_ptr;
	logic [7:0]        flag_reg;
	int                flags_left;
	logic              ref_open;
	logic [7:0]        ref_lo;
	logic [31:0]       bytes_left;
	logic              win_small;
	logic [31:0]       stream_length;
	int                errors = 0;
	int                queue_depth = 0;

	assign fail_count = errors;
	assign pending    = queue_depth;

	function automatic logic [WIN_AW-1:0] index_mask();
		return win_small ? WIN_MASK_SMALL : WIN_MASK_FULL;
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WIN_DEPTH; i++)
			history[i] = 8'h00;
	endtask

	task automatic rearm();
		clear_window();
		wr_ptr     = win_small ? WPOS_RST_SMALL : WPOS_RST_FULL;
		flag_reg   = 8'h00;
		flags_left = 0;
		ref_open   = 1'b0;
		ref_lo     = 8'h00;
		bytes_left = stream_length;
	endtask

	task automatic store_byte(input logic [7:0] b);
		logic [WIN_AW-1:0] mask;
		mask = index_mask();
		history[wr_ptr & mask] = b;
		wr_ptr = (wr_ptr + 1'b1) & mask;
	endtask

	// Decodes one accepted body byte and queues the words it produces.
	task automatic decode_byte(input logic [7:0] b);
		logic [7:0]        copied [0:MAX_COPY-1];
		logic [WIN_AW-1:0] mask;
		logic [WIN_AW-1:0] off;
		logic [7:0]        c;
		logic              ended;
		word_t             w;
		int                n;
		int                len;
		int                k;
		int                pos;
		int                cnt;
		n = 0;
		mask = index_mask();
		if (bytes_left == 0)
			return;
		if (flags_left == 0) begin
			flag_reg = b;
			flags_left = 8;
			return;
		end
		if (flag_reg[0]) begin
			copied[n] = b;
			n++;
			store_byte(b);
			bytes_left--;
		end else if (!ref_open) begin
			ref_lo = b;
			ref_open = 1'b1;
			return;
		end else begin
			if (!win_small) begin
				off = {b[7:4], ref_lo};
				len = int'(b[3:0]) + int'(LEN_BIAS);
			end else begin
				off = {3'b000, b[7], ref_lo};
				len = int'(b[6:0]) + int'(LEN_BIAS);
			end
			for (k = 0; k < len && bytes_left != 0; k++) begin
				c = history[(off + WIN_AW'(k)) & mask];
				copied[n] = c;
				n++;
				bytes_left--;
				// The very last byte of a stream is never written back.
				if (bytes_left != 0)
					store_byte(c);
			end
			ref_open = 1'b0;
		end
		flag_reg = flag_reg >> 1;
		flags_left--;
		ended = (bytes_left == 0);
		for (pos = 0; pos < n; pos += OUT_LANES) begin
			cnt = (n - pos > OUT_LANES) ? OUT_LANES : n - pos;
			w = '0;
			for (k = 0; k < cnt; k++)
				w.data[8*k +: 8] = copied[pos + k];
			w.count = CNT_W'(cnt);
			w.last  = (pos + cnt == n);
			w.done  = w.last && ended;
			predicted_words.push_back(w);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
		end
	endtask

	task automatic compare_word();
		word_t w;
		if (predicted_words.size() == 0) begin
			errors++;
			$display("%0t: unexpected output word, expected none, actual %h count %0d",
				$time, out_bytes, byte_count);
			return;
		end
		w = predicted_words.pop_front();
		check_field("out_bytes", w.data, out_bytes);
		check_field("byte_count", 32'(w.count), 32'(byte_count));
		check_field("run_last", 32'(w.last), 32'(run_last));
		check_field("stream_end", 32'(w.done), 32'(stream_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_small     = 1'b0;
			stream_length = 32'd0;
			rearm();
			wr_ptr = WPOS_RST_FULL;
			predicted_words.delete();
		end else begin
			if (cfg_we) begin
				case (lrwd_reg_t'(cfg_index))
					REG_WINDOW_MODE: win_small = cfg_data[0];
					REG_OUTPUT_LENGTH: begin
						stream_length = cfg_data;
						rearm();
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_byte(in_byte);
			if (out_valid && out_ready)
				compare_word();
		end
		queue_depth = predicted_words.size();
	end

endmodule

// ----- bench/lzss_ring_window_decoder_unit_tb.sv -----
// Testbench top for the LZSS ring-window decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module lzss_ring_window_decoder_unit_tb;
	import lrwd_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	// A reference copies up to 130 bytes, and this pause is meant to cover
	// any copy still running after its last word.
	localparam int QUIET_PAUSE  = 300;
	localparam int HOLD_CYCLES  = 400;
	// The longest correct stretch without a transfer is the pause above plus
	// the clearing pass after a rearm; the limit is several times that.
	localparam int STALL_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 440;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = REG_WINDOW_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [7:0]             in_byte    = 8'h00;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [OUT_W-1:0]       out_bytes;
	logic [CNT_W-1:0]       byte_count;
	logic                   run_last;
	logic                   stream_end;

	int   fail_count;
	int   pending;
	int   send_idle_pct = 16;
	int   recv_idle_pct = 87;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	lzss_ring_window_decoder_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

	lzss_ring_window_decoder_unit_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.run_last   (run_last),
		.stream_end (stream_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Output side. Normally ready is drawn at random each cycle. Once the
	// stimulus arms a hold, the first word that shows up starts a long stretch
	// with ready low, so the output register and the copy engine back up and
	// the block stops taking input while the sender keeps offering bytes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done && out_valid) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("lzss_ring_window_decoder_unit_tb NOT OK");
				$finish;
			end
		end
	end

	// Offers one body byte, with random idle cycles ahead of it, and returns at
	// the edge where the transfer happens. Valid stays high on return so that
	// back-to-back bytes need no gap.
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drops valid and waits until every predicted word has come out, then lets
	// the block finish any copy whose tail produces no further word.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (QUIET_PAUSE)
			@(posedge clk);
	endtask

	task automatic write_reg(input lrwd_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Every stream sends at least one byte after this, and no byte is taken
	// during the clearing pass, so the next call always finds the window clear.
	task automatic start_stream(input logic small_win, input logic [31:0] length);
		wait_idle();
		write_reg(REG_WINDOW_MODE, CFG_DATA_W'(small_win));
		write_reg(REG_OUTPUT_LENGTH, length);
	endtask

	initial begin : stimulus
		logic              small_win;
		logic [31:0]       length;
		logic [7:0]        flag_byte;
		logic [6:0]        code;
		logic [WIN_AW-1:0] gen_ptr;
		logic [WIN_AW-1:0] gen_mask;
		logic [WIN_AW-1:0] off;
		logic              stop;
		int                rand_items;
		int                produced;
		int                sent;
		int                cut;
		int                pick;
		int                slot;
		int                stage;

		rand_items = 0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		// Straight out of reset the stream length is zero, so these bytes are
		// taken after the clearing pass and dropped.
		put_byte(8'hFF);
		put_byte(8'h00);

		// One-byte stream: a single literal ends it, and the byte after the
		// end is dropped.
		start_stream(1'b0, 32'd1);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'hFF);

		// A zero-length stream ignores everything.
		start_stream(1'b0, 32'd0);
		put_byte(8'hA5);
		put_byte(8'h5A);

		// Small window: two literals, then a 130-byte copy that overlaps its
		// own output, a 3-byte copy, and a second long copy that is cut off
		// in the middle by the end of the 200-byte stream.
		start_stream(1'b1, 32'd200);
		put_byte(8'h03);
		put_byte(8'hA5);
		put_byte(8'h5A);
		put_byte(8'h7E);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'h7E);
		put_byte(8'hFF);
		put_byte(8'hC3);

		// Endless stream in the large window, with a switch to the small
		// window between two references; decoding follows the new mode.
		start_stream(1'b0, 32'hFFFF_FFFF);
		put_byte(8'h01);
		put_byte(8'hFF);
		put_byte(8'hEE);
		put_byte(8'hF5);
		wait_idle();
		write_reg(REG_WINDOW_MODE, CFG_DATA_W'(1));
		put_byte(8'h10);
		put_byte(8'h00);

		// Random streams. Most are well formed with random content and run to
		// their end; some are endless and get cut by a rearm, sometimes
		// between the two bytes of a reference.
		while (rand_items < RANDOM_ITEMS) begin
			stage = rand_items * 3 / RANDOM_ITEMS;
			case (stage)
				0: begin
					send_idle_pct <= 16;
					recv_idle_pct <= 87;
				end
				1: begin
					send_idle_pct <= 87;
					recv_idle_pct <= 16;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
					hold_req      <= 1'b1;
				end
			endcase

			small_win = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 7);
			cut = 0;
			if (pick == 0) begin
				length = 32'hFFFF_FFFF;
				cut = $urandom_range(4, 40);
			end else if (pick == 1) begin
				length = $urandom_range(150, 400);
			end else begin
				length = $urandom_range(1, 80);
			end
			start_stream(small_win, length);

			// The generator follows the write pointer so that most references
			// point at bytes written a short way back, often overlapping.
			gen_mask = small_win ? WIN_MASK_SMALL : WIN_MASK_FULL;
			gen_ptr  = small_win ? WPOS_RST_SMALL : WPOS_RST_FULL;
			produced = 0;
			sent = 0;
			stop = 1'b0;
			while (!stop) begin
				flag_byte = 8'($urandom);
				put_byte(flag_byte);
				sent++;
				slot = 0;
				while (slot < 8 && !stop) begin
					if (flag_byte[slot]) begin
						put_byte(8'($urandom));
						sent++;
						produced++;
						gen_ptr = (gen_ptr + 1'b1) & gen_mask;
					end else begin
						if (!small_win)
							code = 7'($urandom_range(0, 15));
						else if ($urandom_range(0, 7) == 0)
							code = 7'($urandom_range(0, 127));
						else
							code = 7'($urandom_range(0, 15));
						if ($urandom_range(0, 3) == 0)
							off = WIN_AW'($urandom);
						else
							off = gen_ptr - WIN_AW'($urandom_range(1, 40));
						off &= gen_mask;
						put_byte(off[7:0]);
						sent++;
						if (cut != 0 && sent >= cut) begin
							stop = 1'b1;
						end else begin
							put_byte(small_win ? {off[8], code} : {off[11:8], code[3:0]});
							sent++;
							produced += int'(code) + 3;
							gen_ptr = (gen_ptr + WIN_AW'(code) + WIN_AW'(3)) & gen_mask;
						end
					end
					if (produced >= length || (cut != 0 && sent >= cut))
						stop = 1'b1;
					slot++;
				end
			end
			// A few bytes past the end of a finished stream are dropped.
			if (cut == 0)
				repeat ($urandom_range(0, 2))
					put_byte(8'($urandom));
			rand_items += sent;
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("lzss_ring_window_decoder_unit_tb OK");
		else
			$display("lzss_ring_window_decoder_unit_tb NOT OK");
		$finish;
	end

endmodule
